/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the escape decoder RTL. They
// expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The condition must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(name, clk, rst_n, prop, msg)

`define ASSERT_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

/* src/escd_pkg.sv */
// ----------------------------------------------------------------------------
// Escape decoder package
// Types, character codes and small helper functions shared by the escape
// sequence decoder modules.
// ----------------------------------------------------------------------------
package escd_pkg;

    // Decoder mode: plain text, backslash seen, one or two octal digits held.
    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_OCT1 = 2'd2,
        MODE_OCT2 = 2'd3
    } mode_t;

    // Characters recognised after a backslash.
    localparam logic [7:0] CHR_BSLASH = 8'h5C;
    localparam logic [7:0] CHR_N      = 8'h6E;
    localparam logic [7:0] CHR_R      = 8'h72;
    localparam logic [7:0] CHR_T      = 8'h74;
    localparam logic [7:0] CHR_A      = 8'h61;
    localparam logic [7:0] CHR_F      = 8'h66;
    localparam logic [7:0] CHR_V      = 8'h76;
    localparam logic [7:0] CHR_ZERO   = 8'h30;

    // Control codes produced by the named escapes.
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_VT  = 8'h0B;

    // One decoded result.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       run_last;
        logic       string_end;
    } result_t;

    // Up to two results produced by one input transfer, oldest in slot 0.
    typedef struct packed {
        result_t [1:0] slot;
        logic [1:0]    count;
    } result_pair_t;

    // True for the ASCII digits 0 to 7.
    function automatic logic is_octal(logic [7:0] b);
        return b[7:3] == CHR_ZERO[7:3];
    endfunction

    // Maps the byte after a backslash to the byte it stands for.
    function automatic logic [7:0] map_escape(logic [7:0] b);
        logic [7:0] code;
        unique case (b)
            CHR_N:   code = CODE_LF;
            CHR_R:   code = CODE_CR;
            CHR_T:   code = CODE_TAB;
            CHR_A:   code = CODE_BEL;
            CHR_F:   code = CODE_FF;
            CHR_V:   code = CODE_VT;
            default: code = b;
        endcase
        return code;
    endfunction

endpackage

/* src/escd_decode.sv */
// ----------------------------------------------------------------------------
// Escape decoder step logic
// Holds the decode mode and the partial octal value, and combinationally
// turns each accepted byte into zero, one or two results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module escd_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            in_byte,
    input  logic                  string_last,
    output escd_pkg::result_pair_t pair
);
    import escd_pkg::*;

    mode_t       mode_reg;
    mode_t       mode_next;
    logic [5:0]  oct_reg;
    logic [5:0]  oct_next;
    result_t     res [2];
    logic [1:0]  n_res;

    logic        in_oct;
    logic [2:0]  digit;
    logic        flush;
    logic        esc_emit;
    logic        full_emit;
    logic        text_go;

    assign in_oct = is_octal(in_byte);
    assign digit  = in_byte[2:0];

    // Mode transition for one byte.
    always_comb
    begin
        mode_next = mode_reg;
        oct_next  = oct_reg;
        flush     = 1'b0;
        esc_emit  = 1'b0;
        full_emit = 1'b0;
        text_go   = 1'b0;
        unique case (mode_reg)
            MODE_TEXT:
            begin
                text_go = 1'b1;
            end
            MODE_ESC:
            begin
                if (in_oct)
                begin
                    oct_next  = {3'b000, digit};
                    mode_next = MODE_OCT1;
                end
                else
                begin
                    esc_emit  = 1'b1;
                    mode_next = MODE_TEXT;
                end
            end
            MODE_OCT1:
            begin
                if (in_oct)
                begin
                    oct_next  = {oct_reg[2:0], digit};
                    mode_next = MODE_OCT2;
                end
                else
                begin
                    flush    = 1'b1;
                    oct_next = '0;
                    text_go  = 1'b1;
                end
            end
            MODE_OCT2:
            begin
                if (in_oct)
                begin
                    full_emit = 1'b1;
                    oct_next  = '0;
                    mode_next = MODE_TEXT;
                end
                else
                begin
                    flush    = 1'b1;
                    oct_next = '0;
                    text_go  = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_TEXT;
            end
        endcase

        // A byte handled as text either opens an escape or passes through.
        if (text_go)
        begin
            mode_next = (in_byte == CHR_BSLASH) ? MODE_ESC : MODE_TEXT;
        end

        // The end of the string flushes a held octal value and resets.
        if (string_last)
        begin
            mode_next = MODE_TEXT;
            oct_next  = '0;
        end
    end

    // Results in order: held octal flush, byte of this step, end flush.
    always_comb
    begin
        res[0] = '0;
        res[1] = '0;
        n_res  = 2'd0;
        if (flush)
        begin
            res[n_res[0]] = '{data: {2'b00, oct_reg}, has_byte: 1'b1,
                              run_last: 1'b0, string_end: 1'b0};
            n_res = n_res + 2'd1;
        end
        if (esc_emit)
        begin
            res[n_res[0]] = '{data: map_escape(in_byte), has_byte: 1'b1,
                              run_last: 1'b0, string_end: 1'b0};
            n_res = n_res + 2'd1;
        end
        if (full_emit)
        begin
            res[n_res[0]] = '{data: {oct_reg[4:0], digit}, has_byte: 1'b1,
                              run_last: 1'b0, string_end: 1'b0};
            n_res = n_res + 2'd1;
        end
        if (text_go && (in_byte != CHR_BSLASH))
        begin
            res[n_res[0]] = '{data: in_byte, has_byte: 1'b1,
                              run_last: 1'b0, string_end: 1'b0};
            n_res = n_res + 2'd1;
        end
        if (string_last)
        begin
            if (esc_emit == 1'b0 && full_emit == 1'b0 && in_oct &&
                (mode_reg == MODE_ESC || mode_reg == MODE_OCT1))
            begin
                // The digit just taken leaves a value held: flush it now.
                res[n_res[0]] = '{data: (mode_reg == MODE_ESC) ? {5'b00000, digit}
                                                               : {2'b00, oct_reg[2:0], digit},
                                  has_byte: 1'b1, run_last: 1'b0, string_end: 1'b0};
                n_res = n_res + 2'd1;
            end
            if (n_res == 2'd0)
            begin
                // End-only marker.
                res[0] = '0;
                n_res  = 2'd1;
            end
            res[n_res[1]].string_end = 1'b1;
        end
        if (n_res != 2'd0)
        begin
            res[n_res[1]].run_last = 1'b1;
        end
    end

    assign pair.slot[0] = res[0];
    assign pair.slot[1] = res[1];
    assign pair.count   = accept ? n_res : 2'd0;

    // Decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_TEXT;
            oct_reg  <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            oct_reg  <= oct_next;
        end
    end

    `ASSERT_CLK(a_end_resets_state, clk, rst_n, (accept && string_last) |=> (mode_reg == MODE_TEXT && oct_reg == 6'd0), "state not cleared after end of string")
    `ASSERT_CLK(a_end_has_result, clk, rst_n, (accept && string_last) |-> (pair.count != 2'd0), "end of string produced no result")
    `ASSERT_CLK(a_one_digit_narrow, clk, rst_n, (mode_reg == MODE_OCT1) |-> (oct_reg[5:3] == 3'd0), "single octal digit out of range")

endmodule

/* src/escd_queue.sv */
// ----------------------------------------------------------------------------
// Escape decoder result queue
// Small register queue that takes up to two results per cycle and hands
// one result per transfer to the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module escd_queue #(
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  escd_pkg::result_pair_t pair,
    output logic                   full,
    output logic                   out_valid,
    input  logic                   out_stall,
    output escd_pkg::result_t      head
);
    import escd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t         mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic [AW-1:0]   wr_p1;
    logic [AW-1:0]   wr_p2;
    logic [AW-1:0]   rd_p1;
    logic            pop;

    // Pointer arithmetic with wrap at the queue depth.
    always_comb
    begin
        wr_p1 = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        wr_p2 = (wr_p1 == AW'(DEPTH - 1)) ? '0 : wr_p1 + 1'b1;
        rd_p1 = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    end

    assign pop       = out_valid && !out_stall;
    assign out_valid = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign full      = (count_reg > CW'(DEPTH - 2));

    // Next pointers and fill level.
    always_comb
    begin
        case (pair.count)
            2'd1:    wr_ptr_next = wr_p1;
            2'd2:    wr_ptr_next = wr_p2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? rd_p1 : rd_ptr_reg;
        count_next  = count_reg + CW'(pair.count) - CW'(pop);
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (pair.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= pair.slot[0];
        end
        if (pair.count == 2'd2)
        begin
            mem[wr_p1] <= pair.slot[1];
        end
    end

    // Queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > CW'(DEPTH), "queue fill level beyond depth")
    `ASSERT_CLK(a_no_overflow, clk, rst_n, (pair.count != 2'd0) |-> ((count_reg + CW'(pair.count)) <= CW'(DEPTH)), "results pushed into a full queue")
    `ASSERT_CLK(a_pop_drains, clk, rst_n, (pop && pair.count == 2'd0) |=> (count_reg == $past(count_reg) - 1'b1), "fill level did not drop on a transfer")

endmodule

/* src/escape_sequence_decoder_top.sv */
// ----------------------------------------------------------------------------
// Escape sequence decoder
// Streaming decoder for C string escapes: named control escapes, octal
// escapes of one to three digits, pass-through of other escaped bytes.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+----------------------------------------
//   input   | in_valid, in_stall  | in_byte, string_last
//   output  | out_valid, out_stall| out_byte, has_byte, run_last, string_end
//
// One input byte is accepted per cycle while two queue slots are free; the
// output hands over one result per transfer, so a byte that yields two
// results takes two output transfers. Results are registered in the queue.
// The input stalls while fewer than two slots of the result queue are free.
// Reset clears the decode mode, the held octal value and the queue.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       string_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       run_last,
    output logic       string_end
);
    import escd_pkg::*;

    logic         accept;
    logic         queue_full;
    result_pair_t pair;
    result_t      head;

    // A transfer is taken whenever the queue can absorb two results.
    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    escd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_byte     (in_byte),
        .string_last (string_last),
        .pair        (pair)
    );

    escd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair      (pair),
        .full      (queue_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    // Output payload from the head of the queue.
    assign out_byte   = head.data;
    assign has_byte   = head.has_byte;
    assign run_last   = head.run_last;
    assign string_end = head.string_end;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape sequence decoder testbench
// Drives escaped strings into the decoder one byte per transfer and checks
// every decoded result against an in-house model of the decode rules or a
// hand-written result. A short table of hand-written cases comes first.
// Random strings of plain text, named, pass-through and octal escapes follow,
// with some noise, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

    import escd_pkg::*;

    localparam logic [7:0] CHR_B     = 8'h62;
    localparam logic [7:0] CHR_SEVEN = 8'h37;
    localparam int         DIR_ROWS  = 28;
    localparam int         PHASE_ITEMS = 125;

    // One planned input byte; typed rows carry their results written by hand.
    typedef struct packed {
        logic [7:0] raw;
        logic       last;
        logic       typed;
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       string_last;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       string_end;

    // Decoder model state.
    mode_t      dec_mode;
    logic [8:0] oct_acc;
    result_t    step_out[$];

    // Rows handed to the input and the decoded results still awaited.
    stim_row_t  pending_rows[$];
    result_t    decoded_q[$];
    logic [7:0] string_bytes[$];

    int idle_pct;
    int stall_pct;
    int items_sent;
    int err_cnt;

    stim_row_t  seen_row;
    result_t    want;

    escape_sequence_decoder_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .string_last (string_last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .run_last    (run_last),
        .string_end  (string_end)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    function automatic result_t res(logic [7:0] d, logic hb, logic rl, logic se);
        result_t r;
        r.data       = d;
        r.has_byte   = hb;
        r.run_last   = rl;
        r.string_end = se;
        return r;
    endfunction

    function automatic logic octal_char(logic [7:0] b);
        return (b >= CHR_ZERO) && (b <= CHR_SEVEN);
    endfunction

    function automatic logic [7:0] control_code(logic [7:0] b);
        case (b)
            CHR_N:   return CODE_LF;
            CHR_R:   return CODE_CR;
            CHR_T:   return CODE_TAB;
            CHR_A:   return CODE_BEL;
            CHR_F:   return CODE_FF;
            CHR_V:   return CODE_VT;
            default: return b;
        endcase
    endfunction

    function automatic void emit(logic [7:0] d);
        step_out.push_back(res(d, 1'b1, 1'b0, 1'b0));
    endfunction

    // A byte seen outside an escape: a backslash opens one, anything else passes.
    function automatic void text_char(logic [7:0] b);
        if (b == CHR_BSLASH) begin
            dec_mode = MODE_ESC;
        end
        else begin
            dec_mode = MODE_TEXT;
            emit(b);
        end
    endfunction

    // Works out the results of one input byte into step_out.
    function automatic void decode_step(logic [7:0] b, logic last);
        logic digit;
        int   idx;
        digit = octal_char(b);
        step_out.delete();
        case (dec_mode)
            MODE_TEXT: text_char(b);
            MODE_ESC:
                if (digit) begin
                    oct_acc  = {6'd0, b[2:0]};
                    dec_mode = MODE_OCT1;
                end
                else begin
                    dec_mode = MODE_TEXT;
                    emit(control_code(b));
                end
            MODE_OCT1:
                if (digit) begin
                    oct_acc  = {oct_acc[5:0], b[2:0]};
                    dec_mode = MODE_OCT2;
                end
                else begin
                    emit(oct_acc[7:0]);
                    oct_acc = '0;
                    text_char(b);
                end
            MODE_OCT2:
                if (digit) begin
                    // The third digit completes the value; only its low byte survives.
                    oct_acc = {oct_acc[5:0], b[2:0]};
                    emit(oct_acc[7:0]);
                    oct_acc  = '0;
                    dec_mode = MODE_TEXT;
                end
                else begin
                    emit(oct_acc[7:0]);
                    oct_acc = '0;
                    text_char(b);
                end
        endcase
        // The end of a string flushes a held octal value; a silent end gives a marker.
        if (last) begin
            if (dec_mode == MODE_OCT1 || dec_mode == MODE_OCT2) begin
                emit(oct_acc[7:0]);
            end
            dec_mode = MODE_TEXT;
            oct_acc  = '0;
            if (step_out.size() == 0) begin
                step_out.push_back(res(8'h00, 1'b0, 1'b0, 1'b0));
            end
            idx = step_out.size() - 1;
            step_out[idx].string_end = 1'b1;
        end
        if (step_out.size() > 0) begin
            idx = step_out.size() - 1;
            step_out[idx].run_last = 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic stim_row_t pred_row(logic [7:0] b, logic last);
        return '{b, last, 1'b0, 2'd0, result_t'('0), result_t'('0)};
    endfunction

    function automatic stim_row_t typed_row(logic [7:0] b, logic last, logic [1:0] n,
                                            result_t r0, result_t r1);
        return '{b, last, 1'b1, n, r0, r1};
    endfunction

    // Presents one byte after a random gap and waits for its transfer.
    task automatic send_row(stim_row_t row);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        pending_rows.push_back(row);
        in_valid    <= 1'b1;
        in_byte     <= row.raw;
        string_last <= row.last;
        @(posedge clk);
        while (in_stall !== 1'b0) begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Holds the input off until every awaited result has been taken.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending_rows.size() != 0 || decoded_q.size() != 0) begin
            @(posedge clk);
        end
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do begin
            if ($urandom_range(0, 3) == 0) begin
                b = 8'($urandom_range(0, 255));
            end
            else begin
                b = 8'($urandom_range(8'h20, 8'h7E));
            end
        end while (b == CHR_BSLASH);
        return b;
    endfunction

    function automatic logic [7:0] named_char();
        case ($urandom_range(0, 5))
            0:       return CHR_N;
            1:       return CHR_R;
            2:       return CHR_T;
            3:       return CHR_A;
            4:       return CHR_F;
            default: return CHR_V;
        endcase
    endfunction

    // A byte after a backslash that is not an octal digit.
    function automatic logic [7:0] other_escaped();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       b = CHR_BSLASH;
            1:       b = CHR_B;
            default:
                do begin
                    b = 8'($urandom_range(0, 255));
                end while (octal_char(b));
        endcase
        return b;
    endfunction

    function automatic logic [7:0] octal_digit();
        return CHR_ZERO + 8'($urandom_range(0, 7));
    endfunction

    // Builds one string into string_bytes: mostly well-formed, sometimes noise.
    function automatic void build_string();
        int tokens;
        int n;
        string_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0:       string_bytes.push_back(CHR_BSLASH);
                    1:       string_bytes.push_back(octal_digit());
                    default: string_bytes.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            return;
        end
        tokens = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 8);
        repeat (tokens) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: string_bytes.push_back(plain_char());
                4: begin
                    string_bytes.push_back(CHR_BSLASH);
                    string_bytes.push_back(named_char());
                end
                5: begin
                    string_bytes.push_back(CHR_BSLASH);
                    string_bytes.push_back(other_escaped());
                end
                6, 7, 8: begin
                    string_bytes.push_back(CHR_BSLASH);
                    n = $urandom_range(1, 3);
                    repeat (n) string_bytes.push_back(octal_digit());
                end
                default: string_bytes.push_back(CHR_BSLASH);
            endcase
        end
    endfunction

    // One traffic phase of random strings, ended by a full drain.
    task automatic run_phase(int idle, int stall);
        int start;
        idle_pct  = idle;
        stall_pct = stall;
        start     = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            build_string();
            foreach (string_bytes[i]) begin
                send_row(pred_row(string_bytes[i], i == string_bytes.size() - 1));
            end
        end
        drain();
    endtask

    // ------------------------------------------------------------------
    // Receiver stalls
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // Transfer watch: predicts on each input transfer, checks each result
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall && pending_rows.size() != 0) begin
            seen_row = pending_rows.pop_front();
            decode_step(in_byte, string_last);
            if (seen_row.typed) begin
                if (seen_row.n > 0) decoded_q.push_back(seen_row.r0);
                if (seen_row.n > 1) decoded_q.push_back(seen_row.r1);
            end
            else begin
                foreach (step_out[i]) decoded_q.push_back(step_out[i]);
            end
        end
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (decoded_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) begin
                    $display("mismatch: unexpected result data=%02h has=%0b last=%0b end=%0b",
                             out_byte, has_byte, run_last, string_end);
                end
            end
            else begin
                want = decoded_q.pop_front();
                if (out_byte !== want.data || has_byte !== want.has_byte ||
                    run_last !== want.run_last || string_end !== want.string_end) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display({"mismatch: expected data=%02h has=%0b last=%0b end=%0b,",
                                  " got data=%02h has=%0b last=%0b end=%0b"},
                                 want.data, want.has_byte, want.run_last, want.string_end,
                                 out_byte, has_byte, run_last, string_end);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        stim_row_t dir_rows [DIR_ROWS];
        result_t   none;

        none        = '0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_byte     = '0;
        string_last = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        items_sent  = 0;
        err_cnt     = 0;
        dec_mode    = MODE_TEXT;
        oct_acc     = '0;

        // Plain bytes at both extremes, then one of every escape form.
        dir_rows[0]  = typed_row(8'h41, 1'b0, 2'd1, res(8'h41, 1'b1, 1'b1, 1'b0), none);
        dir_rows[1]  = typed_row(8'hFF, 1'b0, 2'd1, res(8'hFF, 1'b1, 1'b1, 1'b0), none);
        dir_rows[2]  = typed_row(8'h00, 1'b1, 2'd1, res(8'h00, 1'b1, 1'b1, 1'b1), none);
        dir_rows[3]  = typed_row(CHR_BSLASH, 1'b0, 2'd0, none, none);
        dir_rows[4]  = typed_row(CHR_N, 1'b0, 2'd1, res(CODE_LF, 1'b1, 1'b1, 1'b0), none);
        dir_rows[5]  = pred_row(CHR_BSLASH, 1'b0);
        dir_rows[6]  = pred_row(CHR_R, 1'b0);
        dir_rows[7]  = pred_row(CHR_BSLASH, 1'b0);
        dir_rows[8]  = pred_row(CHR_T, 1'b0);
        dir_rows[9]  = pred_row(CHR_BSLASH, 1'b0);
        dir_rows[10] = pred_row(CHR_A, 1'b0);
        dir_rows[11] = pred_row(CHR_BSLASH, 1'b0);
        dir_rows[12] = pred_row(CHR_F, 1'b0);
        dir_rows[13] = pred_row(CHR_BSLASH, 1'b0);
        dir_rows[14] = pred_row(CHR_V, 1'b0);
        // Escaped backslash passes through.
        dir_rows[15] = pred_row(CHR_BSLASH, 1'b0);
        dir_rows[16] = pred_row(CHR_BSLASH, 1'b0);
        // Three sevens wrap to the low byte.
        dir_rows[17] = pred_row(CHR_BSLASH, 1'b0);
        dir_rows[18] = pred_row(CHR_SEVEN, 1'b0);
        dir_rows[19] = pred_row(CHR_SEVEN, 1'b0);
        dir_rows[20] = typed_row(CHR_SEVEN, 1'b0, 2'd1, res(8'hFF, 1'b1, 1'b1, 1'b0), none);
        // Two digits ended by a letter: the held value, then the letter.
        dir_rows[21] = pred_row(CHR_BSLASH, 1'b0);
        dir_rows[22] = pred_row(8'h31, 1'b0);
        dir_rows[23] = pred_row(8'h32, 1'b0);
        dir_rows[24] = typed_row(8'h78, 1'b0, 2'd2, res(8'h0A, 1'b1, 1'b0, 1'b0),
                                 res(8'h78, 1'b1, 1'b1, 1'b0));
        // One digit held at the end of the string is flushed.
        dir_rows[25] = pred_row(CHR_BSLASH, 1'b0);
        dir_rows[26] = typed_row(CHR_SEVEN, 1'b1, 2'd1, res(8'h07, 1'b1, 1'b1, 1'b1), none);
        // A lone backslash at the end leaves only the end marker.
        dir_rows[27] = typed_row(CHR_BSLASH, 1'b1, 2'd1, res(8'h00, 1'b0, 1'b1, 1'b1), none);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            send_row(dir_rows[i]);
        end
        drain();

        run_phase(0, 0);
        run_phase(65, 0);
        run_phase(0, 65);
        run_phase(25, 25);

        stall_pct = 0;
        repeat (10) @(posedge clk);
        if (decoded_q.size() != 0) begin
            err_cnt += decoded_q.size();
            $display("mismatch: %0d results never arrived", decoded_q.size());
        end

        if (err_cnt == 0) begin
            $display("PASS");
        end
        else begin
            $display("FAIL");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule
